>>> src/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Transaction types, operation codes and status codes shared by the queue core
// and its testbench-facing ports.
// ----------------------------------------------------------------------------
package deq_pkg;

   // Operation codes carried in the request op field.
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_QUERY      = 3'd4;

   // Status codes returned with every response.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   // Word reported for both ends while the queue is empty.
   localparam logic signed [31:0] EMPTY_WORD = '1;

   localparam int WORD_W = 32;
   localparam int OCC_W  = 5;

   typedef struct packed {
      logic [2:0]               op;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] back_value;
      logic                     is_empty;
      logic                     is_full;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;

endpackage

>>> src/deq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read address.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed 32-bit words held in a ring buffer memory.
// ----------------------------------------------------------------------------
// Each request transaction pushes at the front or back, pops from the front
// or back, or only queries; every request yields exactly one response with
// the status, the words at both ends (-1 when empty), the empty and full
// flags and the occupancy. The words at the two ends are cached in
// registers, so pushes, queries, refused operations and pops that leave the
// queue empty answer from the response register alone. A pop that exposes
// a new end word also waits in the read state, because that word comes out
// of the entry memory, whose read data is registered. A new request is
// taken while the previous response is being collected in the same cycle.
// There is no clearing pass after reset; entries are only read once written.
// ----------------------------------------------------------------------------
module double_ended_queue_core
   import deq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
      return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
      return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
   endfunction

   state_type                state_ff, state_in;
   logic [AW-1:0]            front_ff, front_in;
   logic [AW-1:0]            back_ff, back_in;
   logic [CW-1:0]            count_ff, count_in;
   logic signed [WORD_W-1:0] front_word_ff, front_word_in;
   logic signed [WORD_W-1:0] back_word_ff, back_word_in;
   logic                     pend_front_ff, pend_front_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     out_free;
   logic                     req_fire;
   logic                     q_empty;
   logic                     q_full;
   logic [1:0]               status;
   logic                     need_read;
   logic                     ram_wr_en;
   logic [AW-1:0]            ram_wr_addr;
   logic [AW-1:0]            ram_rd_addr;
   logic [WORD_W-1:0]        ram_rd_data;

   // Handshake: take a request only when idle and the response slot frees up.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign req_fire  = req_valid && !req_stall;

   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == CW'(DEPTH));

   // Operation decode and the next queue state.
   always_comb begin
      front_in      = front_ff;
      back_in       = back_ff;
      count_in      = count_ff;
      front_word_in = front_word_ff;
      back_word_in  = back_word_ff;
      pend_front_in = pend_front_ff;
      status        = STATUS_OK;
      need_read     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = back_ff;
      ram_rd_addr   = wrap_inc(front_ff);
      if (req_fire) begin
         unique case (req_data.op)
            OP_PUSH_FRONT: begin
               if (q_full) begin
                  status = STATUS_OVERFLOW;
               end else begin
                  front_in      = wrap_dec(front_ff);
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = wrap_dec(front_ff);
                  count_in      = count_ff + CW'(1);
                  front_word_in = req_data.value;
                  if (q_empty) begin
                     back_word_in = req_data.value;
                  end
               end
            end
            OP_PUSH_BACK: begin
               if (q_full) begin
                  status = STATUS_OVERFLOW;
               end else begin
                  back_in      = wrap_inc(back_ff);
                  ram_wr_en    = 1'b1;
                  ram_wr_addr  = back_ff;
                  count_in     = count_ff + CW'(1);
                  back_word_in = req_data.value;
                  if (q_empty) begin
                     front_word_in = req_data.value;
                  end
               end
            end
            OP_POP_FRONT: begin
               if (q_empty) begin
                  status = STATUS_UNDERFLOW;
               end else begin
                  front_in      = wrap_inc(front_ff);
                  count_in      = count_ff - CW'(1);
                  need_read     = (count_ff != CW'(1));
                  pend_front_in = 1'b1;
                  ram_rd_addr   = wrap_inc(front_ff);
               end
            end
            OP_POP_BACK: begin
               if (q_empty) begin
                  status = STATUS_UNDERFLOW;
               end else begin
                  back_in       = wrap_dec(back_ff);
                  count_in      = count_ff - CW'(1);
                  need_read     = (count_ff != CW'(1));
                  pend_front_in = 1'b0;
                  ram_rd_addr   = wrap_dec(wrap_dec(back_ff));
               end
            end
            default: begin
               // Query and unused codes leave the queue as it is.
               status = STATUS_OK;
            end
         endcase
      end else if (state_ff == S_READ) begin
         // The newly exposed end word returns from memory.
         if (pend_front_ff) begin
            front_word_in = ram_rd_data;
         end else begin
            back_word_in = ram_rd_data;
         end
      end
   end

   // Response register and sequencing.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_data_in.status      = status;
         rsp_data_in.front_value = (count_in == '0) ? EMPTY_WORD : front_word_in;
         rsp_data_in.back_value  = (count_in == '0) ? EMPTY_WORD : back_word_in;
         rsp_data_in.is_empty    = (count_in == '0);
         rsp_data_in.is_full     = (count_in == CW'(DEPTH));
         rsp_data_in.occupancy   = OCC_W'(count_in);
         rsp_valid_in            = !need_read;
         state_in                = need_read ? S_READ : S_IDLE;
      end else if (state_ff == S_READ) begin
         rsp_data_in.front_value = front_word_in;
         rsp_data_in.back_value  = back_word_in;
         rsp_valid_in            = 1'b1;
         state_in                = S_IDLE;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      front_word_ff <= front_word_in;
      back_word_ff  <= back_word_in;
      pend_front_ff <= pend_front_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Entry store.
   deq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data.value),
      .rd_en   (need_read),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The response slot is always empty while a memory read is outstanding.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("response slot occupied during entry read");

   // Occupancy never exceeds the ring size.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   // With the ring empty or full, both indices meet.
   assert property (@(posedge clock) disable iff (reset)
      ((count_ff == '0) || (count_ff == CW'(DEPTH))) |-> (front_ff == back_ff))
      else $error("ring indices inconsistent with entry count");

   // No memory write while a read result is pending.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !ram_wr_en)
      else $error("entry write during pending read");

   // An accepted pop that exposes a new end passes through the read state before its response is valid.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && need_read) |=> (state_ff == S_READ) ##1 rsp_valid_ff)
      else $error("pop response not delivered after entry read");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives push, pop and query transactions into the queue core and checks every
// response against a shadow ring buffer that is kept inside the bench.
// ----------------------------------------------------------------------------
// Directed tests cover the empty queue, the extreme words and overflow on a
// full queue. Random tests then walk the occupancy up and down with drifting
// push/pop mixes, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench
   import deq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH           = 16;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int DRAIN_CYCLES    = 5;

   // Op codes that the core does not define; they behave as a query.
   localparam logic [2:0] OP_UNUSED_LOW  = 3'd5;
   localparam logic [2:0] OP_UNUSED_HIGH = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the queue contents.
   logic signed [WORD_W-1:0] shadow_words [DEPTH];
   int shadow_front = 0;
   int shadow_back  = 0;
   int shadow_count = 0;

   // Responses predicted for accepted requests, oldest first.
   rsp_type snapshots_due [$];

   int error_count       = 0;
   int idle_cycles       = 0;
   int responses_taken   = 0;
   int sender_idle_max   = 12;
   int receiver_idle_max = 12;

   double_ended_queue_core #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Wait length for one transaction; zero turns up often so that
   // back-to-back traffic is mixed in even when idling is enabled.
   function automatic int draw_wait(int max_wait);
      if (max_wait == 0) return 0;
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, max_wait);
   endfunction

   // Applies one request to the shadow queue and returns the response that
   // the core must give for it.
   function automatic rsp_type deque_next_response(req_type item);
      rsp_type snap;
      snap = '0;
      snap.status = STATUS_OK;
      case (item.op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_count == DEPTH) begin
               snap.status = STATUS_OVERFLOW;
            end else if (item.op == OP_PUSH_FRONT) begin
               shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
               shadow_words[shadow_front] = item.value;
               shadow_count++;
            end else begin
               shadow_words[shadow_back] = item.value;
               shadow_back = (shadow_back + 1) % DEPTH;
               shadow_count++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_count == 0) begin
               snap.status = STATUS_UNDERFLOW;
            end else if (item.op == OP_POP_FRONT) begin
               shadow_front = (shadow_front + 1) % DEPTH;
               shadow_count--;
            end else begin
               shadow_back = (shadow_back + DEPTH - 1) % DEPTH;
               shadow_count--;
            end
         end
         default: begin
         end
      endcase
      snap.is_empty  = (shadow_count == 0);
      snap.is_full   = (shadow_count == DEPTH);
      snap.occupancy = OCC_W'(shadow_count);
      if (shadow_count == 0) begin
         snap.front_value = EMPTY_WORD;
         snap.back_value  = EMPTY_WORD;
      end else begin
         snap.front_value = shadow_words[shadow_front];
         snap.back_value  = shadow_words[(shadow_back + DEPTH - 1) % DEPTH];
      end
      return snap;
   endfunction

   task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // Both handshakes are observed here. A request is predicted before the
   // response of the same edge is checked, so ordering never depends on
   // which process runs first.
   always @(posedge clock) begin : monitor
      rsp_type want;
      bit      progress;
      progress = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            snapshots_due.insert(snapshots_due.size(), deque_next_response(req_data));
            progress = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            responses_taken++;
            progress = 1'b1;
            if (snapshots_due.size() == 0) begin
               $error("response transaction with no request waiting for it");
               error_count++;
            end else begin
               want = snapshots_due[0];
               snapshots_due.delete(0);
               check_field("status", WORD_W'(want.status), WORD_W'(rsp_data.status));
               check_field("front_value", want.front_value, rsp_data.front_value);
               check_field("back_value", want.back_value, rsp_data.back_value);
               check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(rsp_data.is_empty));
               check_field("is_full", WORD_W'(want.is_full), WORD_W'(rsp_data.is_full));
               check_field("occupancy", WORD_W'(want.occupancy),
                           WORD_W'(rsp_data.occupancy));
            end
         end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
   end

   // Receiver: after each accepted response, stall for a drawn number of cycles.
   always @(negedge clock) begin : receiver
      int seen_last;
      int hold;
      if (responses_taken != seen_last) begin
         seen_last = responses_taken;
         hold = draw_wait(receiver_idle_max);
      end
      if (hold > 0) begin
         rsp_stall <= 1'b1;
         hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: the run ends when no transaction moves for too long.
   initial begin
      wait (idle_cycles >= WATCHDOG_CYCLES);
      $display("tb: failure");
      $finish;
   end

   // Sends one request transaction after a random gap and returns once the
   // core has accepted it. Valid stays high for a following request.
   task automatic send_request(logic [2:0] op, logic signed [WORD_W-1:0] value);
      int gap;
      gap = draw_wait(sender_idle_max);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data.op    <= op;
      req_data.value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops sending and waits until every predicted response has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (snapshots_due.size() != 0) @(negedge clock);
   endtask

   // Pops and queries on an empty queue, including an unused op code.
   task automatic test_empty_queue();
      send_request(OP_POP_FRONT, 32'sd0);
      send_request(OP_POP_BACK, -32'sd1);
      send_request(OP_QUERY, 32'sd0);
      send_request(OP_UNUSED_LOW, 32'sd5);
   endtask

   // Extreme words at both ends, then pops that expose a stored end word
   // and finally empty the queue.
   task automatic test_extreme_words();
      send_request(OP_PUSH_BACK, 32'sh7fff_ffff);
      send_request(OP_PUSH_FRONT, 32'sh8000_0000);
      send_request(OP_POP_BACK, 32'sd0);
      send_request(OP_POP_FRONT, 32'sd0);
   endtask

   // Fills the queue from both ends, then pushes at each end while full.
   task automatic test_fill_overflow();
      for (int i = 0; i < DEPTH; i++) begin
         send_request((i % 2 == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom());
      end
      send_request(OP_PUSH_FRONT, -32'sd1);
      send_request(OP_PUSH_BACK, 32'sd0);
   endtask

   // Random traffic whose push/pop mix drifts every few dozen transactions,
   // so the occupancy sweeps between empty and full over and over.
   task automatic test_random_traffic(int count, int sender_max, int receiver_max);
      int         push_share;
      int         roll;
      logic [2:0] op;
      sender_idle_max   = sender_max;
      receiver_idle_max = receiver_max;
      push_share        = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 48 == 0) push_share = $urandom_range(15, 85);
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            op = 3'($urandom_range(OP_QUERY, OP_UNUSED_HIGH));
         end else if ($urandom_range(0, 99) < push_share) begin
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         end else begin
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
         end
         send_request(op, $urandom());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_extreme_words();
      test_fill_overflow();
      // Let the core go fully quiet before random traffic starts.
      wait_drained();
      test_random_traffic(400, 12, 12);
      test_random_traffic(300, 0, 0);
      wait_drained();
      test_random_traffic(300, 12, 0);
      test_random_traffic(300, 0, 12);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && snapshots_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
